/* rtl/wbp_pkg.sv */
// ----------------------------------------------------------------------------
// wbp_pkg
// Shared types and constants for the beacon parser: controller states,
// element walk phases, security codes and controller/datapath handshakes.
// ----------------------------------------------------------------------------
package wbp_pkg;

    // default sizes
    localparam int SSID_MAX_DEF  = 32;
    localparam int FRAME_MAX_DEF = 4096;

    // fixed field widths
    localparam int BSSID_W  = 48;
    localparam int CHAN_W   = 8;
    localparam int SEC_W    = 3;
    localparam int SLEN_W   = 6;
    localparam int CHAR_W   = 8;
    localparam int OUT_RAW  = BSSID_W + CHAN_W + SEC_W + SLEN_W + CHAR_W;
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

    // header offsets and codes
    localparam logic [15:0] HS_RTAP     = 16'hFF00;
    localparam logic [15:0] HS_REJECT   = 16'hFFFF;
    localparam logic [15:0] RTAP_MINLEN = 16'd8;
    localparam logic [15:0] OFF_BSSID   = 16'd16;
    localparam logic [15:0] OFF_BSSID_E = 16'd22;
    localparam logic [15:0] OFF_CAP     = 16'd34;
    localparam logic [15:0] OFF_BODY    = 16'd36;
    localparam logic [7:0]  FC_MASK     = 8'hFC;
    localparam logic [7:0]  FC_BEACON   = 8'h80;

    // element ids
    localparam logic [7:0]  EID_SSID    = 8'd0;
    localparam logic [7:0]  EID_DS      = 8'd3;
    localparam logic [7:0]  EID_RSN     = 8'd48;
    localparam logic [7:0]  EID_VENDOR  = 8'd221;
    localparam logic [31:0] WPA_OUI_T   = 32'h0050F201;

    // security codes
    localparam logic [2:0] SEC_OPEN     = 3'd0;
    localparam logic [2:0] SEC_WEP      = 3'd1;
    localparam logic [2:0] SEC_WPA      = 3'd2;
    localparam logic [2:0] SEC_WPA2     = 3'd3;
    localparam logic [2:0] SEC_MIXED    = 3'd4;

    // result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_SSID    = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef enum logic [1:0] {
        PH_ID,
        PH_LEN,
        PH_BODY
    } t_ie_phase;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic rd_en;
        logic load_ssid;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic drain_start;
        logic item_last;
    } t_ctrl_sts;

endpackage

/* rtl/wbp_ctrl.sv */
// ----------------------------------------------------------------------------
// wbp_ctrl
// Sequencer: parses bytes while running, then drains the stored SSID bytes
// one read and one output load at a time.
// ----------------------------------------------------------------------------
module wbp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wbp_pkg::t_ctrl_sts i_sts,
    output wbp_pkg::t_ctrl_cmd o_cmd
);
    import wbp_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.load_ssid = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                o_cmd.in_ready = i_sts.out_free;
                if (i_sts.drain_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_ssid = 1'b1;
                    n_state = i_sts.item_last ? ST_RUN : ST_READ;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

endmodule

/* rtl/wbp_dpath.sv */
// ----------------------------------------------------------------------------
// wbp_dpath
// Parser datapath: byte counter, header tracking, element walk, SSID store
// and the output register.
// ----------------------------------------------------------------------------
module wbp_dpath #(
    parameter int SSID_MAX  = wbp_pkg::SSID_MAX_DEF,
    parameter int FRAME_MAX = wbp_pkg::FRAME_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [7:0]                i_in_data,
    input  logic                      i_in_last,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [wbp_pkg::OUT_W-1:0] o_out_data,
    output logic                      o_out_kind,
    output logic                      o_out_last,
    input  wbp_pkg::t_ctrl_cmd        i_cmd,
    output wbp_pkg::t_ctrl_sts        o_sts
);
    import wbp_pkg::*;

    localparam int          AW      = (SSID_MAX > 1) ? $clog2(SSID_MAX) : 1;
    localparam logic [15:0] FMAX16  = 16'(FRAME_MAX);
    localparam logic [16:0] FMAX17  = 17'(FRAME_MAX);
    localparam logic [7:0]  SMAX8   = 8'(SSID_MAX);
    localparam logic [5:0]  SMAX6   = 6'(SSID_MAX);
    localparam int          PAD_W   = OUT_W - OUT_RAW;

    // parse state
    logic [15:0]          r_pos, n_pos;
    logic [15:0]          r_hs, n_hs;
    logic                 r_beacon, n_beacon;
    logic                 r_priv, n_priv;
    logic [BSSID_W-1:0]   r_bssid, n_bssid;
    t_ie_phase            r_phase, n_phase;
    logic [7:0]           r_eid, n_eid;
    logic [7:0]           r_elen, n_elen;
    logic [7:0]           r_eidx, n_eidx;
    logic [31:0]          r_vword, n_vword;
    logic [5:0]           r_scnt, n_scnt;
    logic                 r_sfound, n_sfound;
    logic [7:0]           r_chan, n_chan;
    logic                 r_cfound, n_cfound;
    logic                 r_rsn, n_rsn;
    logic                 r_wpa, n_wpa;

    // drain and output
    logic [5:0]           r_idx;
    logic [5:0]           r_dcnt;
    logic [7:0]           r_rd_data;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;
    logic                 r_out_kind;
    logic                 r_out_last;
    logic [7:0]           r_mem [SSID_MAX];

    // combinational helpers
    logic                 w_accept;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [15:0]          w_off;
    logic [15:0]          w_rtlen;
    logic                 w_fin;
    logic [7:0]           w_fin_id;
    logic [7:0]           w_fin_len;
    logic [31:0]          w_fin_vw;
    logic [16:0]          w_flen;
    logic                 w_frame_ok;
    logic                 w_sum_load;
    logic [2:0]           w_sec;
    logic [CHAN_W-1:0]    w_chan_out;
    logic [5:0]           w_sum_cnt;
    logic [BSSID_W-1:0]   w_sum_bssid;

    assign w_accept = i_in_valid & i_cmd.in_ready;

    // next-state of the parser for one accepted byte
    always_comb begin
        n_pos     = r_pos;
        n_hs      = r_hs;
        n_beacon  = r_beacon;
        n_priv    = r_priv;
        n_bssid   = r_bssid;
        n_phase   = r_phase;
        n_eid     = r_eid;
        n_elen    = r_elen;
        n_eidx    = r_eidx;
        n_vword   = r_vword;
        n_scnt    = r_scnt;
        n_sfound  = r_sfound;
        n_chan    = r_chan;
        n_cfound  = r_cfound;
        n_rsn     = r_rsn;
        n_wpa     = r_wpa;
        w_we      = 1'b0;
        w_waddr   = r_eidx[AW-1:0];
        w_off     = 16'd0;
        w_rtlen   = {i_in_data, r_hs[7:0]};
        w_fin     = 1'b0;
        w_fin_id  = r_eid;
        w_fin_len = r_elen;
        w_fin_vw  = r_vword;

        if (w_accept) begin
            if (r_pos != 16'hFFFF) begin
                n_pos = r_pos + 16'd1;
            end
            if (r_pos < FMAX16) begin
                // radiotap header tracking
                if (r_pos == 16'd0) begin
                    n_hs = (i_in_data == 8'd0) ? HS_RTAP : 16'd0;
                end else if (r_pos == 16'd2 && r_hs == HS_RTAP) begin
                    n_hs = {8'hFF, i_in_data};
                end else if (r_pos == 16'd3 && r_hs[15:8] == 8'hFF && r_hs != HS_REJECT) begin
                    n_hs = (w_rtlen < RTAP_MINLEN) ? HS_REJECT : w_rtlen;
                end

                // 802.11 header and body
                if (n_hs[15:8] != 8'hFF && r_pos >= n_hs) begin
                    w_off = r_pos - n_hs;
                    if (w_off == 16'd0) begin
                        n_beacon = ((i_in_data & FC_MASK) == FC_BEACON);
                    end else if (w_off >= OFF_BSSID && w_off < OFF_BSSID_E) begin
                        n_bssid = {r_bssid[BSSID_W-9:0], i_in_data};
                    end else if (w_off == OFF_CAP) begin
                        n_priv = i_in_data[4];
                    end else if (w_off >= OFF_BODY) begin
                        // element walk
                        unique case (r_phase)
                            PH_ID: begin
                                n_eid   = i_in_data;
                                n_phase = PH_LEN;
                            end
                            PH_LEN: begin
                                n_elen    = i_in_data;
                                n_eidx    = 8'd0;
                                n_vword   = 32'd0;
                                w_fin_len = i_in_data;
                                w_fin_vw  = 32'd0;
                                if (i_in_data == 8'd0) begin
                                    w_fin = 1'b1;
                                end else begin
                                    n_phase = PH_BODY;
                                end
                            end
                            PH_BODY: begin
                                if (r_eid == EID_SSID && !r_sfound && r_eidx < SMAX8) begin
                                    w_we = 1'b1;
                                end
                                if (r_eid == EID_DS && r_eidx == 8'd0 && !r_cfound) begin
                                    n_chan = i_in_data;
                                end
                                if (r_eid == EID_VENDOR && r_eidx < 8'd4) begin
                                    n_vword = {r_vword[23:0], i_in_data};
                                end
                                n_eidx   = r_eidx + 8'd1;
                                w_fin_vw = n_vword;
                                if (n_eidx == r_elen) begin
                                    w_fin = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = PH_ID;
                            end
                        endcase

                        // element completed
                        if (w_fin) begin
                            n_phase = PH_ID;
                            if (w_fin_id == EID_SSID && !r_sfound) begin
                                n_sfound = 1'b1;
                                n_scnt   = (w_fin_len > SMAX8) ? SMAX6 : w_fin_len[5:0];
                            end else if (w_fin_id == EID_DS && w_fin_len == 8'd1
                                         && !r_cfound) begin
                                n_cfound = 1'b1;
                            end else if (w_fin_id == EID_RSN) begin
                                n_rsn = 1'b1;
                            end else if (w_fin_id == EID_VENDOR && w_fin_len >= 8'd4
                                         && w_fin_vw == WPA_OUI_T) begin
                                n_wpa = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        // frame-end summary, from the state after this byte
        w_flen = {1'b0, r_pos} + 17'd1;
        if (w_flen > FMAX17) begin
            w_flen = FMAX17;
        end
        w_frame_ok = n_beacon && (n_hs[15:8] != 8'hFF)
                     && (w_flen >= ({1'b0, n_hs} + {1'b0, OFF_BODY}));
        if (!n_priv) begin
            w_sec = SEC_OPEN;
        end else if (n_rsn && n_wpa) begin
            w_sec = SEC_MIXED;
        end else if (n_rsn) begin
            w_sec = SEC_WPA2;
        end else if (n_wpa) begin
            w_sec = SEC_WPA;
        end else begin
            w_sec = SEC_WEP;
        end
        w_chan_out  = n_cfound ? n_chan : 8'd0;
        w_sum_cnt   = n_scnt;
        w_sum_bssid = n_bssid;
        w_sum_load  = w_accept && i_in_last && w_frame_ok;

        // frame end clears all parse state
        if (w_accept && i_in_last) begin
            n_pos    = 16'd0;
            n_hs     = 16'd0;
            n_beacon = 1'b0;
            n_priv   = 1'b0;
            n_bssid  = '0;
            n_phase  = PH_ID;
            n_eid    = 8'd0;
            n_elen   = 8'd0;
            n_eidx   = 8'd0;
            n_vword  = 32'd0;
            n_scnt   = 6'd0;
            n_sfound = 1'b0;
            n_chan   = 8'd0;
            n_cfound = 1'b0;
            n_rsn    = 1'b0;
            n_wpa    = 1'b0;
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 16'd0;
            r_hs     <= 16'd0;
            r_beacon <= 1'b0;
            r_priv   <= 1'b0;
            r_bssid  <= '0;
            r_phase  <= PH_ID;
            r_eid    <= 8'd0;
            r_elen   <= 8'd0;
            r_eidx   <= 8'd0;
            r_vword  <= 32'd0;
            r_scnt   <= 6'd0;
            r_sfound <= 1'b0;
            r_chan   <= 8'd0;
            r_cfound <= 1'b0;
            r_rsn    <= 1'b0;
            r_wpa    <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_hs     <= n_hs;
            r_beacon <= n_beacon;
            r_priv   <= n_priv;
            r_bssid  <= n_bssid;
            r_phase  <= n_phase;
            r_eid    <= n_eid;
            r_elen   <= n_elen;
            r_eidx   <= n_eidx;
            r_vword  <= n_vword;
            r_scnt   <= n_scnt;
            r_sfound <= n_sfound;
            r_chan   <= n_chan;
            r_cfound <= n_cfound;
            r_rsn    <= n_rsn;
            r_wpa    <= n_wpa;
        end
    end

    // SSID store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_in_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // drain index and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 6'd0;
            r_dcnt <= 6'd0;
        end else if (w_sum_load) begin
            r_idx  <= 6'd0;
            r_dcnt <= w_sum_cnt;
        end else if (i_cmd.load_ssid) begin
            r_idx  <= r_idx + 6'd1;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sum_load || i_cmd.load_ssid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_sum_load) begin
            r_out_kind <= KIND_SUMMARY;
            r_out_data <= {{PAD_W{1'b0}}, {CHAR_W{1'b0}}, w_sum_cnt, w_sec,
                           w_chan_out, w_sum_bssid};
            r_out_last <= (w_sum_cnt == 6'd0);
        end else if (i_cmd.load_ssid) begin
            r_out_kind <= KIND_SSID;
            r_out_data <= {{PAD_W{1'b0}}, r_rd_data, {SLEN_W{1'b0}}, {SEC_W{1'b0}},
                           {CHAN_W{1'b0}}, {BSSID_W{1'b0}}};
            r_out_last <= o_sts.item_last;
        end
    end

    // status to the controller
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.drain_start = w_sum_load && (w_sum_cnt != 6'd0);
    assign o_sts.item_last   = ((r_idx + 6'd1) == r_dcnt);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

endmodule

/* rtl/wifi_beacon_parser.sv */
// ----------------------------------------------------------------------------
// wifi_beacon_parser
// Streaming 802.11 beacon parser: skips a radiotap header, walks the
// information elements and reports BSSID, channel, security and SSID.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        end marker
//  s_axis    in   tdata[7:0] frame byte                          tlast = frame end
//  m_axis    out  tuser kind, tdata bssid/chan/sec/len/char      tlast = run end
//
//  One frame byte is taken per cycle while parsing; the summary is registered
//  on the cycle that takes the final byte.
//  Each SSID byte then takes one store read and then one output load;
//  input is held off for the whole drain.
//  Input also stalls while the output register is full and not taken.
//  Synchronous active-low reset returns the parser to the start of a frame.
// ----------------------------------------------------------------------------
module wifi_beacon_parser #(
    parameter int SSID_MAX  = wbp_pkg::SSID_MAX_DEF,
    parameter int FRAME_MAX = wbp_pkg::FRAME_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // data_byte[7:0]
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // bssid[47:0], channel_number[55:48], security_kind[58:56],
    // ssid_length[64:59], ssid_char[72:65], zero pad[79:73]
    output logic [wbp_pkg::OUT_W-1:0] m_axis_tdata,
    output logic [0:0]                m_axis_tuser,  // item_kind[0]
    output logic                      m_axis_tlast
);
    import wbp_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;
    logic      w_kind;

    wbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    wbp_dpath #(
        .SSID_MAX  (SSID_MAX),
        .FRAME_MAX (FRAME_MAX)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (w_kind),
        .o_out_last  (m_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    assign s_axis_tready = w_cmd.in_ready;
    assign m_axis_tuser  = w_kind;

    // no input transfer right after a store read (drain in progress)
    a_no_input_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |=> !s_axis_tready)
        else $error("input accepted during SSID drain");

    // an SSID load never overwrites a result still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_ssid |-> (!m_axis_tvalid || m_axis_tready))
        else $error("SSID load over pending result");

    // a summary result carries no SSID character
    a_summary_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SUMMARY) |-> (m_axis_tdata[72:65] == 8'd0))
        else $error("summary with nonzero ssid_char");

endmodule
